// ===== sv/sha_pkg.sv =====
package sha_pkg;

    // number of words in a digest and index of its final word
    localparam int unsigned DIGEST_WORDS = 8;
    localparam logic [2:0] LAST_DIGEST_INDEX = 3'(DIGEST_WORDS - 1);

    // padding marker byte placed in the top byte of a word
    localparam logic [31:0] PAD_MARKER = 32'h8000_0000;

    // buffer slot that takes the high half of the bit length
    localparam logic [3:0] LEN_SLOT = 4'd14;

    localparam logic [31:0] INITIAL_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] x, input logic [31:0] y,
                                           input logic [31:0] z);
        choose = (x & y) ^ (~x & z);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] x, input logic [31:0] y,
                                             input logic [31:0] z);
        majority = (x & y) ^ (x & z) ^ (y & z);
    endfunction

endpackage

// ===== sv/sha256_message_hasher.sv =====
// SHA-256 hasher for byte messages delivered as big-endian 32-bit words, one item per
// accepted input. Words are shifted into a 16-word buffer one per cycle while idle; each
// full block then runs through one shared round unit and a final step folds the result
// into the chaining value, with in_stall high during the rounds. On the item marked last
// the block pushes the padding words (one per cycle outside the compressions, from two
// up to eighteen), runs one or two more compressions, and presents the eight digest
// words one item per cycle while out_stall is low on the output channel; no input is
// taken until the eighth digest word is taken.
module sha256_message_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  digest_index,
    output logic        last_result
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_MARK,
        S_ZERO,
        S_LEN_HI,
        S_LEN_LO,
        S_ROUND,
        S_UPDATE,
        S_OUT
    } state_t;

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;
    logic [3:0]  pos_reg, pos_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;
    logic [63:0] count_reg, count_next;
    logic [31:0] hv_reg [8];
    logic [31:0] hv_next [8];
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];

    logic        push_en;
    logic [31:0] push_word;
    state_t      after_push;
    logic [2:0]  nb;
    logic [31:0] byte_mask;
    logic [31:0] marker;
    logic [31:0] masked_word;
    logic [31:0] sched_word;
    logic [31:0] t1;
    logic [31:0] t2;

    // byte count and masking of the incoming word
    always_comb
    begin
        if (!last_of_message || valid_bytes > 3'd4)
        begin
            nb = 3'd4;
        end
        else
        begin
            nb = valid_bytes;
        end
        case (nb)
            3'd0:    begin byte_mask = 32'h0000_0000; marker = 32'h8000_0000; end
            3'd1:    begin byte_mask = 32'hff00_0000; marker = 32'h0080_0000; end
            3'd2:    begin byte_mask = 32'hffff_0000; marker = 32'h0000_8000; end
            3'd3:    begin byte_mask = 32'hffff_ff00; marker = 32'h0000_0080; end
            default: begin byte_mask = 32'hffff_ffff; marker = 32'h0000_0000; end
        endcase
        masked_word = data_word & byte_mask;
    end

    // shared round unit and schedule expansion
    always_comb
    begin
        sched_word = sha_pkg::small_sigma1(w_reg[14]) + w_reg[9]
                   + sha_pkg::small_sigma0(w_reg[1]) + w_reg[0];
        t1 = v_reg[7] + sha_pkg::big_sigma1(v_reg[4])
           + sha_pkg::choose(v_reg[4], v_reg[5], v_reg[6])
           + sha_pkg::ROUND_K[round_reg] + w_reg[0];
        t2 = sha_pkg::big_sigma0(v_reg[0]) + sha_pkg::majority(v_reg[0], v_reg[1], v_reg[2]);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        pos_next   = pos_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        hv_next    = hv_reg;
        w_next     = w_reg;
        v_next     = v_reg;
        push_en    = 1'b0;
        push_word  = '0;
        after_push = S_IDLE;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    count_next = count_reg + {58'd0, nb, 3'b000};
                    push_en    = 1'b1;
                    if (!last_of_message)
                    begin
                        push_word  = masked_word;
                        after_push = S_IDLE;
                    end
                    else if (nb < 3'd4)
                    begin
                        push_word  = masked_word | marker;
                        after_push = (4'(pos_reg + 4'd1) == sha_pkg::LEN_SLOT) ?
                                     S_LEN_HI : S_ZERO;
                    end
                    else
                    begin
                        push_word  = masked_word;
                        after_push = S_MARK;
                    end
                end
            end
            S_MARK:
            begin
                push_en    = 1'b1;
                push_word  = sha_pkg::PAD_MARKER;
                after_push = (4'(pos_reg + 4'd1) == sha_pkg::LEN_SLOT) ? S_LEN_HI : S_ZERO;
            end
            S_ZERO:
            begin
                push_en    = 1'b1;
                push_word  = '0;
                after_push = (4'(pos_reg + 4'd1) == sha_pkg::LEN_SLOT) ? S_LEN_HI : S_ZERO;
            end
            S_LEN_HI:
            begin
                push_en    = 1'b1;
                push_word  = count_reg[63:32];
                after_push = S_LEN_LO;
            end
            S_LEN_LO:
            begin
                push_en    = 1'b1;
                push_word  = count_reg[31:0];
                after_push = S_OUT;
            end
            S_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[15] = sched_word;
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hv_next[i] = hv_reg[i] + v_reg[i];
                end
                idx_next   = '0;
                state_next = ret_reg;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sha_pkg::LAST_DIGEST_INDEX)
                    begin
                        hv_next    = sha_pkg::INITIAL_HASH;
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // shift a word into the buffer, start the rounds when it fills
        if (push_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = push_word;
            pos_next   = pos_reg + 4'd1;
            if (pos_reg == 4'd15)
            begin
                state_next = S_ROUND;
                ret_next   = after_push;
                round_next = '0;
                v_next     = hv_reg;
            end
            else
            begin
                state_next = after_push;
            end
        end
    end

    // control state, chaining value and bit count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            pos_reg   <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
            count_reg <= '0;
            hv_reg    <= sha_pkg::INITIAL_HASH;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            pos_reg   <= pos_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            hv_reg    <= hv_next;
        end
    end

    // message buffer and working variables
    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        v_reg <= v_next;
    end

    // handshake and digest outputs
    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = (state_reg == S_OUT);
    assign digest_word  = hv_reg[idx_reg];
    assign digest_index = idx_reg;
    assign last_result  = (idx_reg == sha_pkg::LAST_DIGEST_INDEX);

endmodule

// ===== sv/sha_checker.sv =====
module sha_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [31:0] data_word,
    input logic [2:0]  valid_bytes,
    input logic        last_of_message,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] digest_word,
    input logic [2:0]  digest_index,
    input logic        last_result
);

    // a stalled digest item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digest_word)
                                   && $stable(digest_index))
        else $error("digest item changed while stalled");

    // no input is taken while the digest is being delivered
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input ready during digest output");

    // digest words follow one another in order
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_result |=>
            out_valid && digest_index == 3'($past(digest_index) + 3'd1))
        else $error("digest index did not advance");

    // the final flag marks the last digest word only
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> last_result == (digest_index == sha_pkg::LAST_DIGEST_INDEX))
        else $error("last flag on wrong digest word");

    // a word that does not end a message produces no digest
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !last_of_message |=> !out_valid)
        else $error("digest output after a non-final word");

endmodule

bind sha256_message_hasher sha_checker u_sha_checker (.*);

// ===== test/sha256_digest_checker.sv =====
`timescale 1ns / 1ps

module sha256_digest_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_of_message,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] digest_word,
    input  logic [2:0]  digest_index,
    input  logic        last_result,
    output int          fail_count,
    output int          digests_pending
);

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_item_t;

    // predicted hash state
    logic [31:0] chain_h [8];
    logic [31:0] block_w [16];
    logic [3:0]  fill_pos;
    logic [63:0] bit_total;

    digest_item_t digest_q [$];
    int mismatch_reports;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // 64 rounds over the buffered block, schedule rolled in place
    task automatic compress_block();
        logic [31:0] v [8];
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 8; i++)
            v[i] = chain_h[i];
        for (int t = 0; t < 64; t++)
        begin
            if (t >= 16)
            begin
                x = block_w[(t + 1) % 16];
                y = block_w[(t + 14) % 16];
                block_w[t % 16] = block_w[t % 16]
                    + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3))
                    + block_w[(t + 9) % 16]
                    + (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10));
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + block_w[t % 16];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_h[i] = chain_h[i] + v[i];
    endtask

    task automatic buffer_word(input logic [31:0] w);
        block_w[fill_pos] = w;
        fill_pos = fill_pos + 4'd1;
        if (fill_pos == 4'd0)
            compress_block();
    endtask

    // absorb one input item, padding and emitting the digest on the last word
    task automatic absorb_item(input logic [31:0] data, input logic [2:0] nb,
                               input logic lst);
        logic [31:0] w;
        int n;
        n = nb;
        if (!lst || n > 4)
            n = 4;
        w = (n == 0) ? 32'd0 : (data & (32'hffff_ffff << (32 - 8 * n)));
        bit_total = bit_total + 64'(8 * n);
        if (!lst)
        begin
            buffer_word(w);
            return;
        end
        if (n < 4)
            buffer_word(w | (32'h80 << (24 - 8 * n)));
        else
        begin
            buffer_word(w);
            buffer_word(PAD_WORD);
        end
        // no room left for the length: finish this block with zeros
        if (fill_pos > 4'd14)
            while (fill_pos != 4'd0)
                buffer_word(32'd0);
        while (fill_pos < 4'd14)
            buffer_word(32'd0);
        buffer_word(bit_total[63:32]);
        buffer_word(bit_total[31:0]);
        for (int i = 0; i < 8; i++)
        begin
            digest_q.push_back('{word: chain_h[i], index: 3'(i), last: (i == 7)});
            chain_h[i] = START_HASH[i];
        end
        fill_pos = 4'd0;
        bit_total = 64'd0;
    endtask

    // compare accepted digest items, then predict from accepted input items
    always @(posedge clk or negedge rst_n)
    begin
        digest_item_t exp_item;
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                chain_h[i] = START_HASH[i];
            for (int i = 0; i < 16; i++)
                block_w[i] = 32'd0;
            fill_pos = 4'd0;
            bit_total = 64'd0;
            digest_q.delete();
            fail_count = 0;
            mismatch_reports = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (digest_q.size() == 0)
                begin
                    fail_count++;
                    if (mismatch_reports < MAX_REPORTS)
                        $display("digest item with none expected: word %h index %0d last %0b",
                                 digest_word, digest_index, last_result);
                    mismatch_reports++;
                end
                else
                begin
                    exp_item = digest_q.pop_front();
                    if (digest_word !== exp_item.word || digest_index !== exp_item.index
                        || last_result !== exp_item.last)
                    begin
                        fail_count++;
                        if (mismatch_reports < MAX_REPORTS)
                            $display("digest mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                                     exp_item.word, exp_item.index, exp_item.last,
                                     digest_word, digest_index, last_result);
                        mismatch_reports++;
                    end
                end
            end
            if (in_valid && !in_stall)
                absorb_item(data_word, valid_bytes, last_of_message);
        end
        digests_pending = digest_q.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_ITEMS   = 400;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 100;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last_of_message;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        last_result;

    int fail_count;
    int digests_pending;
    int burst_left;
    int items_sent;
    int idle_cycles;
    bit hold_req;
    bit hold_taken;

    sha256_message_hasher u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_word       (data_word),
        .valid_bytes     (valid_bytes),
        .last_of_message (last_of_message),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .digest_word     (digest_word),
        .digest_index    (digest_index),
        .last_result     (last_result)
    );

    sha256_digest_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_word       (data_word),
        .valid_bytes     (valid_bytes),
        .last_of_message (last_of_message),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .digest_word     (digest_word),
        .digest_index    (digest_index),
        .last_result     (last_result),
        .fail_count      (fail_count),
        .digests_pending (digests_pending)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // offer one word, opening a random gap between bursts
    task automatic send_word(input logic [31:0] w, input logic [2:0] nb, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 10));
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        in_valid        <= 1'b1;
        data_word       <= w;
        valid_bytes     <= nb;
        last_of_message <= lst;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        items_sent++;
    endtask

    // whole message of random words; non-last words carry a random byte count
    task automatic send_message(input int len, input logic [2:0] last_nb);
        logic [31:0] w;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 7))
                0: w = 32'd0;
                1: w = 32'hffff_ffff;
                default: w = $urandom;
            endcase
            if (i == len - 1)
                send_word(w, last_nb, 1'b1);
            else
                send_word(w, 3'($urandom_range(0, 7)), 1'b0);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int len;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        data_word       = 32'd0;
        valid_bytes     = 3'd0;
        last_of_message = 1'b0;
        burst_left      = 0;
        items_sent      = 0;
        hold_req        = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // empty message, lower bytes dropped, full and single byte last words
        send_word(32'hdead_beef, 3'd0, 1'b1);
        send_word(32'h6162_63ff, 3'd3, 1'b1);
        send_word(32'hffff_ffff, 3'd4, 1'b1);
        send_word(32'hffff_ffff, 3'd1, 1'b1);
        // byte counts above four on the last word
        send_word(32'h0000_0000, 3'd5, 1'b1);
        send_word(32'h1234_5678, 3'd6, 1'b1);
        send_word(32'hffff_ffff, 3'd7, 1'b1);
        // short count on a word that is not last
        send_word(32'hffff_ffff, 3'd2, 1'b0);
        send_word(32'h0000_0000, 3'd4, 1'b1);
        // length spills into a second padding block
        send_message(14, 3'd4);

        // random messages, long hold-off on the digest side starts here
        hold_req   = 1'b1;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(30, 48);
                1, 2, 3: len = $urandom_range(13, 17);
                default: len = $urandom_range(1, 12);
            endcase
            send_message(len, 3'($urandom_range(0, 7)));
        end

        // drain
        @(negedge clk);
        in_valid <= 1'b0;
        while (digests_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && digests_pending == 0)
            $display("sha256_message_hasher verification clean");
        else
            $display("sha256_message_hasher verification failed");
        $finish;
    end

    // digest side stall pattern, with one long hold-off
    initial
    begin
        int mode;
        int span;
        out_stall  = 1'b0;
        hold_taken = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 64);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sha256_message_hasher verification failed");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
sv/sha_pkg.sv
sv/sha256_message_hasher.sv
sv/sha_checker.sv
test/sha256_digest_checker.sv
test/tb_top.sv
